// File: design/mbvw_pkg.sv
package mbvw_pkg;

    // Access kinds carried in s_tuser.
    typedef enum logic [1:0] {
        KIND_READ_BYTE  = 2'd0,
        KIND_READ_WORD  = 2'd1,
        KIND_WRITE_BYTE = 2'd2,
        KIND_WRITE_WORD = 2'd3
    } kind_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_PIXEL_SCALE  = 2'd2
    } cfg_index_t;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_RD_ISSUE = 8'b0000_0010,
        ST_RD_CAPT  = 8'b0000_0100,
        ST_WR_BYTE  = 8'b0000_1000,
        ST_WR_XY    = 8'b0001_0000,
        ST_WR_BASE  = 8'b0010_0000,
        ST_PIX      = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    localparam logic [9:0]  FRAME_WIDTH_RESET  = 10'd640;
    localparam logic [10:0] FRAME_HEIGHT_RESET = 11'd480;
    localparam logic [2:0]  PIXEL_SCALE_RESET  = 3'd1;

    // The video window is 0xC0000..0xFFFFF: the top twelve bits are zero and
    // bits 19:18 are both set.
    localparam logic [11:0] VIDEO_TOP_BITS = 12'h000;
    localparam logic [1:0]  VIDEO_WIN_BITS = 2'b11;

    // The offset is divided by 640 as (offset >> 7) / 5, and the division by
    // five is a multiplication by 3277 / 2^14, exact for values below 2^14.
    localparam logic [11:0] RECIP_FIVE       = 12'd3277;
    localparam int          RECIP_FIVE_SHIFT = 14;

    // Multiplies a small value by a pixel scale of zero to four; any other scale gives zero.
    function automatic logic [13:0] scale_mul(input logic [11:0] v, input logic [2:0] s);
        logic [13:0] w;
        logic [13:0] r;
        w = {2'b00, v};
        case (s)
            3'd1: r = w;
            3'd2: r = w << 1;
            3'd3: r = w + (w << 1);
            3'd4: r = w << 2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: design/mbvw_byte_mem.sv
module mbvw_byte_mem #(
    parameter int ADDR_BITS = 20
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [7:0]           wdata,
    output logic [7:0]           rdata
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: design/memory_bus_with_video_writethrough_core.sv
// Flow: a read passes ST_RD_ISSUE and ST_RD_CAPT once per byte of the item and then
// finishes in ST_DONE; a write passes ST_WR_BYTE and ST_WR_XY per byte, and for a byte
// that paints ST_WR_BASE and then ST_PIX once per pixel, before ST_DONE finishes the item.
// One item at a time: s_tready is high only in ST_IDLE; result stalls stretch the
// pixel and finishing states. The single memory port and the pixel counters set the pace.
// Reset clears control state and the configuration registers; memory contents persist.
module memory_bus_with_video_writethrough_core
    import mbvw_pkg::*;
#(
    parameter int MEM_ADDR_BITS   = 20,
    parameter int MAX_PIXEL_SCALE = 4
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // address[31:0], write_data[63:32]
    input  logic [1:0]  s_tuser,   // kind[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // read_data[31:0], pixel_address[55:32], pixel_color_index[63:56]
    output logic        m_tuser,   // pixel_valid
    output logic        m_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    localparam logic [2:0] MAX_SCALE = 3'(MAX_PIXEL_SCALE);

    state_t state_reg, state_next;

    logic [9:0]  frame_width_reg;
    logic [10:0] frame_height_reg;
    logic [2:0]  pixel_scale_reg;

    logic [1:0]  kind_reg,     kind_next;
    logic [31:0] addr_reg,     addr_next;
    logic [31:0] data_reg,     data_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;

    logic        hold_valid_reg, hold_valid_next;
    logic [31:0] hold_rdata_reg, hold_rdata_next;
    logic        hold_pv_reg,    hold_pv_next;
    logic [23:0] hold_pa_reg,    hold_pa_next;
    logic [7:0]  hold_pc_reg,    hold_pc_next;

    logic        in_range_reg, in_range_next;
    logic [17:0] off_reg,      off_next;
    logic [8:0]  q_reg,        q_next;
    logic [7:0]  color_reg,    color_next;
    logic [11:0] row_len_reg,  row_len_next;
    logic [10:0] sy_reg,       sy_next;
    logic [11:0] sx_reg,       sx_next;
    logic [23:0] row_base_reg, row_base_next;
    logic [1:0]  pi_reg,       pi_next;
    logic [1:0]  pj_reg,       pj_next;

    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_data_reg,  m_data_next;
    logic        m_user_reg,  m_user_next;
    logic        m_last_reg,  m_last_next;

    logic                     mem_we;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic [7:0]               mem_wdata;
    logic [7:0]               mem_rdata;

    logic        out_free;
    logic        last_byte;
    logic [2:0]  scale_eff;
    logic [1:0]  scale_m1;
    logic [31:0] byte_addr;
    logic [10:0] off_hi;
    logic [22:0] q_prod;
    logic [13:0] row_len_full;
    logic [17:0] x_full;
    logic [9:0]  x_val;
    logic [13:0] sy_full;
    logic [13:0] sx_full;
    logic        paint;
    logic [22:0] base_prod;
    logic [23:0] base_sum;

    mbvw_byte_mem #(
        .ADDR_BITS(MEM_ADDR_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;
    assign m_tlast   = m_last_reg;

    assign out_free  = !m_valid_reg || m_tready;
    assign last_byte = (kind_reg == KIND_READ_BYTE) || (kind_reg == KIND_WRITE_BYTE)
                       || (byte_idx_reg == 2'd3);
    assign scale_eff = (pixel_scale_reg > MAX_SCALE) ? MAX_SCALE : pixel_scale_reg;
    assign scale_m1  = 2'(scale_eff - 3'd1);

    assign byte_addr = addr_reg + {30'd0, byte_idx_reg};
    assign mem_addr  = byte_addr[MEM_ADDR_BITS-1:0];
    assign mem_wdata = data_reg[{byte_idx_reg, 3'b000} +: 8];

    // Pixel geometry, split over the write states.
    assign off_hi       = byte_addr[17:7];
    assign q_prod       = off_hi * RECIP_FIVE;
    assign row_len_full = scale_mul({2'b00, frame_width_reg}, scale_eff);
    assign x_full       = off_reg - ({q_reg, 9'd0} + {2'b00, q_reg, 7'd0});
    assign x_val        = x_full[9:0];
    assign sy_full      = scale_mul({3'b000, q_reg}, scale_eff);
    assign sx_full      = scale_mul({2'b00, x_val}, scale_eff);
    assign paint        = in_range_reg && (x_val < frame_width_reg)
                          && ({2'b00, q_reg} < frame_height_reg) && (scale_eff != 3'd0);
    assign base_prod    = sy_reg * row_len_reg;
    assign base_sum     = {1'b0, base_prod} + {12'd0, sx_reg};

    always_comb begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        byte_idx_next   = byte_idx_reg;
        hold_valid_next = hold_valid_reg;
        hold_rdata_next = hold_rdata_reg;
        hold_pv_next    = hold_pv_reg;
        hold_pa_next    = hold_pa_reg;
        hold_pc_next    = hold_pc_reg;
        in_range_next   = in_range_reg;
        off_next        = off_reg;
        q_next          = q_reg;
        color_next      = color_reg;
        row_len_next    = row_len_reg;
        sy_next         = sy_reg;
        sx_next         = sx_reg;
        row_base_next   = row_base_reg;
        pi_next         = pi_reg;
        pj_next         = pj_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        mem_we          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next       = s_tuser;
                    addr_next       = s_tdata[31:0];
                    data_next       = s_tdata[63:32];
                    byte_idx_next   = 2'd0;
                    hold_valid_next = 1'b0;
                    hold_rdata_next = '0;
                    if ((s_tuser == KIND_READ_BYTE) || (s_tuser == KIND_READ_WORD)) begin
                        state_next = ST_RD_ISSUE;
                    end else begin
                        state_next = ST_WR_BYTE;
                    end
                end
            end
            ST_RD_ISSUE: begin
                state_next = ST_RD_CAPT;
            end
            ST_RD_CAPT: begin
                hold_rdata_next[{byte_idx_reg, 3'b000} +: 8] = mem_rdata;
                if (last_byte) begin
                    hold_valid_next = 1'b1;
                    hold_pv_next    = 1'b0;
                    hold_pa_next    = '0;
                    hold_pc_next    = '0;
                    state_next      = ST_DONE;
                end else begin
                    byte_idx_next = byte_idx_reg + 2'd1;
                    state_next    = ST_RD_ISSUE;
                end
            end
            ST_WR_BYTE: begin
                mem_we        = 1'b1;
                in_range_next = (byte_addr[31:20] == VIDEO_TOP_BITS)
                                && (byte_addr[19:18] == VIDEO_WIN_BITS);
                off_next      = byte_addr[17:0];
                q_next        = q_prod[22:RECIP_FIVE_SHIFT];
                color_next    = mem_wdata;
                row_len_next  = row_len_full[11:0];
                state_next    = ST_WR_XY;
            end
            ST_WR_XY: begin
                sy_next = sy_full[10:0];
                sx_next = sx_full[11:0];
                if (paint) begin
                    state_next = ST_WR_BASE;
                end else if (last_byte) begin
                    state_next = ST_DONE;
                end else begin
                    byte_idx_next = byte_idx_reg + 2'd1;
                    state_next    = ST_WR_BYTE;
                end
            end
            ST_WR_BASE: begin
                row_base_next = base_sum;
                pi_next       = 2'd0;
                pj_next       = 2'd0;
                state_next    = ST_PIX;
            end
            ST_PIX: begin
                // The previous result is held back one beat so that the final
                // one of the item can carry tlast.
                if (!hold_valid_reg || out_free) begin
                    if (hold_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_data_next  = {hold_pc_reg, hold_pa_reg, hold_rdata_reg};
                        m_user_next  = hold_pv_reg;
                        m_last_next  = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_rdata_next = '0;
                    hold_pv_next    = 1'b1;
                    hold_pa_next    = row_base_reg + {22'd0, pj_reg};
                    hold_pc_next    = color_reg;
                    if (pj_reg == scale_m1) begin
                        pj_next       = 2'd0;
                        row_base_next = row_base_reg + {12'd0, row_len_reg};
                        if (pi_reg == scale_m1) begin
                            if (last_byte) begin
                                state_next = ST_DONE;
                            end else begin
                                byte_idx_next = byte_idx_reg + 2'd1;
                                state_next    = ST_WR_BYTE;
                            end
                        end else begin
                            pi_next = pi_reg + 2'd1;
                        end
                    end else begin
                        pj_next = pj_reg + 2'd1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_last_next  = 1'b1;
                    if (hold_valid_reg) begin
                        m_data_next = {hold_pc_reg, hold_pa_reg, hold_rdata_reg};
                        m_user_next = hold_pv_reg;
                    end else begin
                        m_data_next = '0;
                        m_user_next = 1'b0;
                    end
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            hold_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            pixel_scale_reg  <= PIXEL_SCALE_RESET;
        end else begin
            state_reg      <= state_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[9:0];
                    CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[10:0];
                    CFG_PIXEL_SCALE:  pixel_scale_reg  <= cfg_data[2:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        addr_reg       <= addr_next;
        data_reg       <= data_next;
        byte_idx_reg   <= byte_idx_next;
        hold_rdata_reg <= hold_rdata_next;
        hold_pv_reg    <= hold_pv_next;
        hold_pa_reg    <= hold_pa_next;
        hold_pc_reg    <= hold_pc_next;
        in_range_reg   <= in_range_next;
        off_reg        <= off_next;
        q_reg          <= q_next;
        color_reg      <= color_next;
        row_len_reg    <= row_len_next;
        sy_reg         <= sy_next;
        sx_reg         <= sx_next;
        row_base_reg   <= row_base_next;
        pi_reg         <= pi_next;
        pj_reg         <= pj_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

endmodule
